// ===== src/udprx_pkg.sv =====
// ----------------------------------------------------------------------------
// udprx_pkg: shared types and helpers for the UDP receive checker
// Verdict codes, socket slot table type and one's complement fold helpers.
// ----------------------------------------------------------------------------
package udprx_pkg;

   localparam int unsigned NUM_SLOTS  = 4;
   localparam int unsigned SLOT_W     = 2;
   localparam int unsigned HEADER_LEN = 8;

   localparam logic [15:0] UDP_PROTOCOL = 16'd17;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

   localparam logic [1:0] VERDICT_ACCEPTED  = 2'd0;
   localparam logic [1:0] VERDICT_TOO_SHORT = 2'd1;
   localparam logic [1:0] VERDICT_BAD_CSUM  = 2'd2;
   localparam logic [1:0] VERDICT_NO_PORT   = 2'd3;

   // header byte positions
   localparam logic [15:0] IDX_SPORT_HI = 16'd0;
   localparam logic [15:0] IDX_SPORT_LO = 16'd1;
   localparam logic [15:0] IDX_DPORT_HI = 16'd2;
   localparam logic [15:0] IDX_DPORT_LO = 16'd3;
   localparam logic [15:0] IDX_LEN_HI   = 16'd4;
   localparam logic [15:0] IDX_LEN_LO   = 16'd5;

   typedef logic [NUM_SLOTS-1:0][15:0] port_table_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [15:0] pseudo_sum;
   } item_type;

   // end-around carry of a 17-bit sum
   function automatic logic [15:0] fold17(input logic [16:0] s);
      logic [16:0] t;
      t = {1'b0, s[15:0]} + {16'd0, s[16]};
      return t[15:0];
   endfunction

   // end-around carry of a sum of up to eight 16-bit terms
   function automatic logic [15:0] fold19(input logic [18:0] s);
      logic [16:0] t;
      t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
      return fold17(t);
   endfunction

endpackage

// ===== src/udprx_in_stage.sv =====
// ----------------------------------------------------------------------------
// udprx_in_stage: input register of the UDP receive checker
// Captures each byte transaction and the folded IP pseudo-header sum.
// ----------------------------------------------------------------------------
module udprx_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   input  logic [31:0]        req_source_ip,
   input  logic [31:0]        req_dest_ip,
   input  logic               advance,
   output logic               item_valid,
   output udprx_pkg::item_type item
);
   import udprx_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff, s1_item_in;
   logic       take;
   logic [18:0] pseudo_raw;

   assign req_ready = !s1_valid_ff || advance;
   assign take      = req_valid && req_ready;

   // pseudo-header: both addresses and the protocol; length field is added later
   assign pseudo_raw = {3'd0, req_source_ip[31:16]} + {3'd0, req_source_ip[15:0]}
                     + {3'd0, req_dest_ip[31:16]}   + {3'd0, req_dest_ip[15:0]}
                     + {3'd0, UDP_PROTOCOL};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (take) begin
         s1_valid_in           = 1'b1;
         s1_item_in.data_byte  = req_data_byte;
         s1_item_in.last_byte  = req_last_byte;
         s1_item_in.pseudo_sum = fold19(pseudo_raw);
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_item_ff <= s1_item_in;
   end

   assign item_valid = s1_valid_ff;
   assign item       = s1_item_ff;

endmodule

// ===== src/udprx_core.sv =====
// ----------------------------------------------------------------------------
// udprx_core: datagram state, checksum, verdict and result register
// Updates the parse and checksum state per byte and registers the result.
// ----------------------------------------------------------------------------
module udprx_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  udprx_pkg::item_type       item,
   output logic                      advance,
   input  udprx_pkg::port_table_type open_ports,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_verdict,
   output logic [1:0]                rsp_socket_slot,
   output logic [15:0]               rsp_source_port,
   output logic [15:0]               rsp_dst_port,
   output logic [15:0]               rsp_payload_length
);
   import udprx_pkg::*;

   logic [15:0] count_ff, count_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  pend_ff, pend_in;
   logic [15:0] sport_ff, sport_in;
   logic [15:0] dport_ff, dport_in;
   logic [15:0] lenf_ff, lenf_in;
   logic        phase_ff, phase_in;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  verdict_ff, verdict_in;
   logic [1:0]  slot_ff, slot_in;
   logic [15:0] out_sport_ff, out_sport_in;
   logic [15:0] out_dport_ff, out_dport_in;
   logic [15:0] payload_ff, payload_in;

   logic [15:0] base_sum;
   logic [15:0] word_add;
   logic [15:0] len_add;
   logic [17:0] sum_raw;
   logic [16:0] sum_mid;
   logic [15:0] sum_new;
   logic [15:0] count_new;
   logic        csum_good;
   logic [NUM_SLOTS-1:0] hit;
   logic        deliver;

   assign advance = item_valid && (!item.last_byte || !out_valid_ff || rsp_ready);
   assign deliver = advance && item.last_byte;

   always_comb begin
      sport_in = sport_ff;
      dport_in = dport_ff;
      lenf_in  = lenf_ff;
      len_add  = 16'd0;
      unique case (count_ff)
         IDX_SPORT_HI: sport_in = {item.data_byte, 8'd0};
         IDX_SPORT_LO: sport_in = {sport_ff[15:8], item.data_byte};
         IDX_DPORT_HI: dport_in = {item.data_byte, 8'd0};
         IDX_DPORT_LO: dport_in = {dport_ff[15:8], item.data_byte};
         IDX_LEN_HI:   lenf_in  = {item.data_byte, 8'd0};
         IDX_LEN_LO: begin
            lenf_in = {lenf_ff[15:8], item.data_byte};
            len_add = {lenf_ff[15:8], item.data_byte};
         end
         default: ;
      endcase
   end

   // first byte starts from the pseudo-header sum
   assign base_sum = (count_ff == 16'd0) ? item.pseudo_sum : sum_ff;

   // low byte closes a word; an odd final byte is padded with a zero low byte
   always_comb begin
      if (phase_ff) begin
         word_add = {pend_ff, item.data_byte};
      end else if (item.last_byte) begin
         word_add = {item.data_byte, 8'd0};
      end else begin
         word_add = 16'd0;
      end
   end

   assign sum_raw   = {2'd0, base_sum} + {2'd0, word_add} + {2'd0, len_add};
   assign sum_mid   = {1'b0, sum_raw[15:0]} + {15'd0, sum_raw[17:16]};
   assign sum_new   = fold17(sum_mid);
   assign count_new = (count_ff == COUNT_MAX) ? count_ff : count_ff + 16'd1;
   assign pend_in   = phase_ff ? pend_ff : item.data_byte;
   assign csum_good = (sum_new == 16'h0000) || (sum_new == 16'hFFFF);

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         hit[i] = (open_ports[i] != 16'd0) && (open_ports[i] == dport_in);
      end
   end

   always_comb begin
      verdict_in = VERDICT_NO_PORT;
      slot_in    = '0;
      payload_in = count_new - 16'(HEADER_LEN);
      if (count_new < 16'(HEADER_LEN)) begin
         verdict_in = VERDICT_TOO_SHORT;
         payload_in = 16'd0;
      end else if (!csum_good) begin
         verdict_in = VERDICT_BAD_CSUM;
      end else begin
         // lowest matching slot wins
         for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (hit[i]) begin
               verdict_in = VERDICT_ACCEPTED;
               slot_in    = SLOT_W'(i);
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      phase_in = phase_ff;
      if (deliver) begin
         // clear for the next datagram
         count_in = 16'd0;
         sum_in   = 16'd0;
         phase_in = 1'b0;
      end else if (advance) begin
         count_in = count_new;
         sum_in   = sum_new;
         phase_in = !phase_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (deliver) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign out_sport_in = sport_in;
   assign out_dport_in = dport_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 16'd0;
         sum_ff       <= 16'd0;
         phase_ff     <= 1'b0;
         pend_ff      <= 8'd0;
         sport_ff     <= 16'd0;
         dport_ff     <= 16'd0;
         lenf_ff      <= 16'd0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         if (deliver) begin
            pend_ff  <= 8'd0;
            sport_ff <= 16'd0;
            dport_ff <= 16'd0;
            lenf_ff  <= 16'd0;
         end else if (advance) begin
            pend_ff  <= pend_in;
            sport_ff <= sport_in;
            dport_ff <= dport_in;
            lenf_ff  <= lenf_in;
         end
      end
      if (deliver) begin
         verdict_ff   <= verdict_in;
         slot_ff      <= slot_in;
         out_sport_ff <= out_sport_in;
         out_dport_ff <= out_dport_in;
         payload_ff   <= payload_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_verdict        = verdict_ff;
   assign rsp_socket_slot    = slot_ff;
   assign rsp_source_port    = out_sport_ff;
   assign rsp_dst_port       = out_dport_ff;
   assign rsp_payload_length = payload_ff;

`ifndef SYNTHESIS
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 16'd0) |-> !phase_ff)
      else $error("phase set with empty datagram");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      deliver |=> (count_ff == 16'd0) && (sum_ff == 16'd0))
      else $error("datagram state not cleared after last byte");

   a_accept_port: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (verdict_ff == VERDICT_ACCEPTED)) |-> (out_dport_ff != 16'd0))
      else $error("accepted datagram on port zero");

   a_short_payload: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (verdict_ff == VERDICT_TOO_SHORT)) |-> (payload_ff == 16'd0))
      else $error("short datagram with nonzero payload length");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !deliver)
      else $error("result overwritten while stalled");
`endif

endmodule

// ===== src/udp_receive_checksum_port_demux.sv =====
// ----------------------------------------------------------------------------
// udp_receive_checksum_port_demux: UDP checksum verify and port demultiplexer
// Throughput: one byte transaction per cycle, sustained; a last byte waits only
// while the previous result is still held by a stalled receiver.
// Result path: the accepted last byte is held in the input register, then the
// checksum/verdict logic writes the result register that drives the result outputs.
// Reset: synchronous; clears datagram state, result valid and all socket ports.
// ----------------------------------------------------------------------------
module udp_receive_checksum_port_demux (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_source_ip,
   input  logic [31:0] req_dest_ip,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict,
   output logic [1:0]  rsp_socket_slot,
   output logic [15:0] rsp_source_port,
   output logic [15:0] rsp_dst_port,
   output logic [15:0] rsp_payload_length,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import udprx_pkg::*;

   port_table_type ports_ff, ports_in;
   logic           item_valid;
   item_type       item;
   logic           advance;

   always_comb begin
      ports_in = ports_ff;
      if (csr_wr_en) begin
         ports_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ports_ff <= '0;
      end else begin
         ports_ff <= ports_in;
      end
   end

   udprx_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_source_ip (req_source_ip),
      .req_dest_ip   (req_dest_ip),
      .advance       (advance),
      .item_valid    (item_valid),
      .item          (item)
   );

   udprx_core u_core (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (item_valid),
      .item               (item),
      .advance            (advance),
      .open_ports         (ports_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_verdict        (rsp_verdict),
      .rsp_socket_slot    (rsp_socket_slot),
      .rsp_source_port    (rsp_source_port),
      .rsp_dst_port       (rsp_dst_port),
      .rsp_payload_length (rsp_payload_length)
   );

endmodule

// ===== dv/udp_receive_checksum_port_demux_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP receive checker: datagram verdict predictor and result scoreboard
// Watches the byte, result and register channels of the block. It tracks the
// port table and the per-datagram parse and checksum state, predicts one
// verdict per datagram and compares every result field in arrival order.
// ----------------------------------------------------------------------------
module udp_receive_checksum_port_demux_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_source_ip,
   input  logic [31:0] req_dest_ip,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_verdict,
   input  logic [1:0]  rsp_socket_slot,
   input  logic [15:0] rsp_source_port,
   input  logic [15:0] rsp_dst_port,
   input  logic [15:0] rsp_payload_length,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int unsigned fail_count,
   output int unsigned expected_left,
   output int unsigned results_checked,
   output int unsigned accepted_seen
);
   import udprx_pkg::*;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [1:0]  slot;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] payload;
   } dgram_verdict_type;

   dgram_verdict_type verdict_q[$];
   port_table_type    port_tab;

   logic [15:0] byte_cnt;
   logic [15:0] csum;
   logic [7:0]  hi_byte;
   logic [15:0] sport;
   logic [15:0] dport;
   logic [15:0] len_field;
   logic        low_phase;

   int unsigned errs;
   int unsigned n_checked;
   int unsigned n_accepted;

   function automatic logic [15:0] oc_sum(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   task automatic clear_datagram_state();
      byte_cnt  = '0;
      csum      = '0;
      hi_byte   = '0;
      sport     = '0;
      dport     = '0;
      len_field = '0;
      low_phase = 1'b0;
   endtask

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      $display("%0t ERROR %s: expected %0h got %0h", $time, what, want, got);
      errs++;
   endtask

   // fold one byte into the datagram state; queue a verdict on the last byte
   task automatic absorb_byte(input logic [7:0] b, input logic last,
                              input logic [31:0] sip, input logic [31:0] dip);
      logic [15:0]       idx;
      dgram_verdict_type res;
      logic              found;
      int unsigned       i;
      if (byte_cnt == 0) begin
         clear_datagram_state();
         csum = oc_sum(csum, sip[31:16]);
         csum = oc_sum(csum, sip[15:0]);
         csum = oc_sum(csum, dip[31:16]);
         csum = oc_sum(csum, dip[15:0]);
         csum = oc_sum(csum, UDP_PROTOCOL);
      end
      idx = byte_cnt;
      if (!low_phase) begin
         hi_byte = b;
      end else begin
         csum = oc_sum(csum, {hi_byte, b});
      end
      case (idx)
         IDX_SPORT_HI: sport = {b, 8'h00};
         IDX_SPORT_LO: sport = sport | {8'h00, b};
         IDX_DPORT_HI: dport = {b, 8'h00};
         IDX_DPORT_LO: dport = dport | {8'h00, b};
         IDX_LEN_HI:   len_field = {b, 8'h00};
         IDX_LEN_LO: begin
            len_field = len_field | {8'h00, b};
            csum = oc_sum(csum, len_field);
         end
         default: ;
      endcase
      low_phase = !low_phase;
      if (byte_cnt != COUNT_MAX) byte_cnt = byte_cnt + 16'd1;
      if (last) begin
         // odd final byte: pad with a zero low byte
         if (low_phase) csum = oc_sum(csum, {hi_byte, 8'h00});
         res.sport = sport;
         res.dport = dport;
         res.slot  = '0;
         if (byte_cnt < 16'(HEADER_LEN)) begin
            res.verdict = VERDICT_TOO_SHORT;
            res.payload = '0;
         end else begin
            res.payload = byte_cnt - 16'(HEADER_LEN);
            if (csum != 16'hFFFF && csum != 16'h0000) begin
               res.verdict = VERDICT_BAD_CSUM;
            end else begin
               res.verdict = VERDICT_NO_PORT;
               found = 1'b0;
               for (i = 0; i < NUM_SLOTS; i++) begin
                  if (!found && port_tab[i] != 16'h0000 && port_tab[i] == dport) begin
                     found       = 1'b1;
                     res.verdict = VERDICT_ACCEPTED;
                     res.slot    = SLOT_W'(i);
                  end
               end
            end
         end
         verdict_q.push_back(res);
         clear_datagram_state();
      end
   endtask

   task automatic check_result();
      dgram_verdict_type want;
      if (verdict_q.size() == 0) begin
         report("result with no datagram pending, verdict", '0, 32'(rsp_verdict));
      end else begin
         want = verdict_q.pop_front();
         if (rsp_verdict !== want.verdict) begin
            report("verdict", 32'(want.verdict), 32'(rsp_verdict));
         end
         if (rsp_socket_slot !== want.slot) begin
            report("socket_slot", 32'(want.slot), 32'(rsp_socket_slot));
         end
         if (rsp_source_port !== want.sport) begin
            report("source_port", 32'(want.sport), 32'(rsp_source_port));
         end
         if (rsp_dst_port !== want.dport) begin
            report("dst_port", 32'(want.dport), 32'(rsp_dst_port));
         end
         if (rsp_payload_length !== want.payload) begin
            report("payload_length", 32'(want.payload), 32'(rsp_payload_length));
         end
         n_checked++;
         if (want.verdict == VERDICT_ACCEPTED) n_accepted++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         port_tab = '0;
         clear_datagram_state();
         verdict_q.delete();
      end else begin
         if (csr_wr_en) port_tab[csr_index] = csr_wdata;
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready) begin
            absorb_byte(req_data_byte, req_last_byte, req_source_ip, req_dest_ip);
         end
      end
      fail_count      <= errs;
      expected_left   <= $unsigned(verdict_q.size());
      results_checked <= n_checked;
      accepted_seen   <= n_accepted;
   end

endmodule

// ===== dv/udp_receive_checksum_port_demux_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP receive checksum and port demux testbench
// Sends UDP datagrams byte by byte: a directed set covering closed and
// duplicate slots, short, odd and bad-checksum datagrams, then random
// traffic under changing port tables, with bursty sending and a
// stalling receiver. A checker beside the block scores every result.
// ----------------------------------------------------------------------------
module udp_receive_checksum_port_demux_tb;
   import udprx_pkg::*;

   localparam int unsigned IDLE_LIMIT        = 2000;
   localparam int unsigned RANDOM_BYTES      = 660;
   localparam int unsigned RANDOM_DGRAMS_MIN = 40;
   localparam int unsigned DRAIN_CYCLES      = 8;
   localparam int unsigned TABLE_EVERY       = 12;

   typedef enum logic [1:0] {FAULT_NONE, FAULT_FLIP, FAULT_RAW} fault_type;
   typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_STARVED} rx_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic [31:0] req_source_ip;
   logic [31:0] req_dest_ip;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_verdict;
   logic [1:0]  rsp_socket_slot;
   logic [15:0] rsp_source_port;
   logic [15:0] rsp_dst_port;
   logic [15:0] rsp_payload_length;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   int unsigned fail_count;
   int unsigned expected_left;
   int unsigned results_checked;
   int unsigned accepted_seen;

   logic [7:0]     dgram[$];
   port_table_type ports_now;
   int unsigned    burst_left;
   int unsigned    bytes_sent;
   int unsigned    dgrams_sent;
   int unsigned    tables_written;
   int unsigned    quiet_cycles;
   bit             steady;

   rx_mode_type rx_mode;
   int unsigned rx_left;
   int unsigned rx_phase;

   udp_receive_checksum_port_demux dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_source_ip      (req_source_ip),
      .req_dest_ip        (req_dest_ip),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_verdict        (rsp_verdict),
      .rsp_socket_slot    (rsp_socket_slot),
      .rsp_source_port    (rsp_source_port),
      .rsp_dst_port       (rsp_dst_port),
      .rsp_payload_length (rsp_payload_length),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   udp_receive_checksum_port_demux_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_source_ip      (req_source_ip),
      .req_dest_ip        (req_dest_ip),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_verdict        (rsp_verdict),
      .rsp_socket_slot    (rsp_socket_slot),
      .rsp_source_port    (rsp_source_port),
      .rsp_dst_port       (rsp_dst_port),
      .rsp_payload_length (rsp_payload_length),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .expected_left      (expected_left),
      .results_checked    (results_checked),
      .accepted_seen      (accepted_seen)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: %0d cycles without a transaction", quiet_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: switch at random between stall patterns
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
         RX_ALWAYS:   rsp_ready <= 1'b1;
         RX_COIN:     rsp_ready <= ($urandom_range(0, 1) == 1);
         RX_PERIODIC: rsp_ready <= ((rx_phase % 5) < 3);
         RX_STARVED:  rsp_ready <= ($urandom_range(0, 7) == 0);
         default:     rsp_ready <= 1'b1;
      endcase
   end

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   function automatic logic [31:0] pick_ip();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h0000_0000;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic logic [15:0] pick_dport();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6) return ports_now[$urandom_range(0, NUM_SLOTS - 1)];
      if (r < 8) return 16'($urandom);
      if (r == 8) return 16'h0000;
      return 16'hFFFF;
   endfunction

   function automatic port_table_type random_ports();
      port_table_type t;
      int unsigned    i;
      int unsigned    r;
      t = '0;
      for (i = 0; i < NUM_SLOTS; i++) begin
         r = $urandom_range(0, 19);
         if (r < 5) t[i] = 16'h0000;
         else if (r < 7) t[i] = 16'hFFFF;
         else if (r < 10 && i > 0) t[i] = t[i - 1];
         else t[i] = 16'($urandom_range(1, 65535));
      end
      return t;
   endfunction

   // write the whole port table, one register per cycle
   task automatic load_ports(input port_table_type tbl);
      int unsigned i;
      for (i = 0; i < NUM_SLOTS; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= tbl[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      ports_now = tbl;
      tables_written++;
   endtask

   // drop valid and wait until every verdict has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_left != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // build a datagram (sealed with a good checksum unless faulted) and send it
   task automatic transmit(input int unsigned n, input logic [15:0] sport,
                           input logic [15:0] dport, input logic [15:0] len_field,
                           input logic [31:0] sip, input logic [31:0] dip,
                           input fault_type fault);
      logic [15:0] acc;
      int unsigned i;
      int unsigned gap;
      dgram.delete();
      dgram.push_back(sport[15:8]);
      dgram.push_back(sport[7:0]);
      dgram.push_back(dport[15:8]);
      dgram.push_back(dport[7:0]);
      dgram.push_back(len_field[15:8]);
      dgram.push_back(len_field[7:0]);
      dgram.push_back(8'h00);
      dgram.push_back(8'h00);
      while (dgram.size() < n) dgram.push_back(8'($urandom));
      if (fault == FAULT_RAW) begin
         dgram[6] = 8'($urandom);
         dgram[7] = 8'($urandom);
      end else begin
         acc = ones_add(sip[31:16], sip[15:0]);
         acc = ones_add(acc, dip[31:16]);
         acc = ones_add(acc, dip[15:0]);
         acc = ones_add(acc, UDP_PROTOCOL);
         acc = ones_add(acc, len_field);
         for (i = 0; i < dgram.size(); i += 2) begin
            acc = ones_add(acc, {dgram[i], (i + 1 < dgram.size()) ? dgram[i + 1] : 8'h00});
         end
         acc = ~acc;
         dgram[6] = acc[15:8];
         dgram[7] = acc[7:0];
         if (fault == FAULT_FLIP) begin
            i = $urandom_range(0, dgram.size() - 1);
            dgram[i] = dgram[i] ^ (8'h01 << $urandom_range(0, 7));
         end
      end
      while (dgram.size() > n) void'(dgram.pop_back());

      for (i = 0; i < dgram.size(); i++) begin
         gap = 0;
         if (!steady) begin
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // addresses only count on the first byte; scramble them elsewhere
         req_valid     <= 1'b1;
         req_data_byte <= dgram[i];
         req_last_byte <= (i == dgram.size() - 1);
         req_source_ip <= (i == 0) ? sip : $urandom;
         req_dest_ip   <= (i == 0) ? dip : $urandom;
         do @(posedge clock); while (!req_ready);
         bytes_sent++;
      end
      dgrams_sent++;
   endtask

   initial begin
      logic [31:0] sip;
      logic [31:0] dip;
      int unsigned n;
      int unsigned kind;
      int unsigned rnd_start;
      int unsigned rnd_dgrams;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= '0;
      req_last_byte <= 1'b0;
      req_source_ip <= '0;
      req_dest_ip   <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      ports_now      = '0;
      steady         = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all slots closed after reset
      transmit(8, 16'h0000, 16'h0035, 16'd8, 32'h0000_0000, 32'h0000_0000, FAULT_NONE);
      drain();

      // slot 0 = 0x0035, slot 1 and slot 3 share 0xFFFF, slot 2 = 0x0001
      load_ports({16'hFFFF, 16'h0001, 16'hFFFF, 16'h0035});
      transmit(8, 16'hFFFF, 16'hFFFF, 16'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, FAULT_NONE);
      transmit(9, 16'h1234, 16'h0001, 16'd9, pick_ip(), pick_ip(), FAULT_NONE);
      transmit(1, 16'hA5A5, 16'h0035, 16'd1, pick_ip(), pick_ip(), FAULT_NONE);
      transmit(7, 16'h5A5A, 16'h0035, 16'd7, pick_ip(), pick_ip(), FAULT_NONE);
      transmit(12, 16'h0400, 16'h0035, 16'd12, pick_ip(), pick_ip(), FAULT_FLIP);
      transmit(10, 16'h0101, 16'h0000, 16'd10, pick_ip(), pick_ip(), FAULT_NONE);
      // length field disagrees with the byte count
      transmit(11, 16'h7FFF, 16'h0035, 16'h0400, pick_ip(), pick_ip(), FAULT_NONE);
      drain();

      // closed slots around one open port
      load_ports({16'h0000, 16'h0000, 16'h0001, 16'h0000});
      transmit(8, 16'h8000, 16'h0000, 16'd8, pick_ip(), pick_ip(), FAULT_NONE);
      transmit(9, 16'hABCD, 16'h0001, 16'd9, pick_ip(), pick_ip(), FAULT_NONE);
      drain();

      rnd_start  = bytes_sent;
      rnd_dgrams = 0;
      while (bytes_sent - rnd_start < RANDOM_BYTES || rnd_dgrams < RANDOM_DGRAMS_MIN) begin
         if (rnd_dgrams % TABLE_EVERY == 0) begin
            drain();
            load_ports(random_ports());
         end
         steady = ($urandom_range(0, 4) == 0);
         sip    = pick_ip();
         dip    = pick_ip();
         n      = $urandom_range(8, 24);
         kind   = $urandom_range(0, 9);
         if (kind < 7) begin
            transmit(n, 16'($urandom), pick_dport(),
                     ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(n), sip, dip, FAULT_NONE);
         end else if (kind == 7) begin
            n = $urandom_range(1, 7);
            transmit(n, 16'($urandom), pick_dport(), 16'(n), sip, dip, FAULT_NONE);
         end else if (kind == 8) begin
            transmit(n, 16'($urandom), pick_dport(), 16'(n), sip, dip, FAULT_FLIP);
         end else begin
            n = $urandom_range(1, 30);
            transmit(n, 16'($urandom), 16'($urandom), 16'($urandom), sip, dip, FAULT_RAW);
         end
         rnd_dgrams++;
      end
      steady = 1'b0;
      drain();

      $display("Sent %0d datagrams (%0d bytes) under %0d port tables",
               dgrams_sent, bytes_sent, tables_written);
      $display("Checked %0d verdicts, %0d of them accepted", results_checked, accepted_seen);
      if (fail_count == 0 && expected_left == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/udprx_pkg.sv
src/udprx_in_stage.sv
src/udprx_core.sv
src/udp_receive_checksum_port_demux.sv
dv/udp_receive_checksum_port_demux_checker.sv
dv/udp_receive_checksum_port_demux_tb.sv
